FILE: rtl/core/swrm_pkg.sv
// Shared types and constants for the sliding-window range tracker.
// No dependencies; used by every module under rtl/core except swrm_minmax_tree.
package swrm_pkg;

    // Width of the window length register
    localparam int unsigned LEN_W = 5;

    // Window length after reset
    localparam logic [LEN_W-1:0] LEN_RESET = 5'd1;

    // Per-request control carried alongside the sample data
    typedef struct packed {
        logic full;
        logic first;
        logic last;
    } swrm_ctrl_t;

endpackage

FILE: rtl/core/sliding_window_range_max.sv
// Sliding-window range tracker, top level: window, comparator tree, result stages.
// Depends on swrm_pkg, swrm_window, swrm_minmax_tree, swrm_result.
// Registers: window, min/max, output; one request per cycle while out_ready is high.
// The comparator tree sits combinationally between the window register and the min/max register.
// Reset clears valids, fill count and best range and sets window_len to 1; samples are not cleared.
module sliding_window_range_max #(
    parameter int WINDOW_MAX  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [swrm_pkg::LEN_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          first,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          window_full,
    output logic signed [SAMPLE_BITS-1:0] window_min,
    output logic signed [SAMPLE_BITS-1:0] window_max,
    output logic [SAMPLE_BITS-1:0]        window_range,
    output logic [SAMPLE_BITS-1:0]        best_range,
    output logic                          too_short
);

    logic                          s1_valid;
    logic                          s2_en;
    swrm_pkg::swrm_ctrl_t          s1_ctrl;
    logic signed [SAMPLE_BITS-1:0] taps [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] tree_lo;
    logic signed [SAMPLE_BITS-1:0] tree_hi;

    swrm_window #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .first       (first),
        .last        (last),
        .s2_en       (s2_en),
        .s1_valid    (s1_valid),
        .s1_ctrl     (s1_ctrl),
        .taps        (taps)
    );

    swrm_minmax_tree #(
        .N (WINDOW_MAX),
        .W (SAMPLE_BITS)
    ) u_tree (
        .taps (taps),
        .lo   (tree_lo),
        .hi   (tree_hi)
    );

    swrm_result #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .s1_valid     (s1_valid),
        .s1_ctrl      (s1_ctrl),
        .tree_lo      (tree_lo),
        .tree_hi      (tree_hi),
        .s2_en        (s2_en),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_full  (window_full),
        .window_min   (window_min),
        .window_max   (window_max),
        .window_range (window_range),
        .best_range   (best_range),
        .too_short    (too_short)
    );

endmodule

FILE: rtl/core/swrm_window.sv
// Window shift register, fill counter and window length register (stage 1).
// Depends on swrm_pkg.
module swrm_window #(
    parameter int WINDOW_MAX  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [swrm_pkg::LEN_W-1:0]       cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [SAMPLE_BITS-1:0]    sample,
    input  logic                             first,
    input  logic                             last,
    input  logic                             s2_en,
    output logic                             s1_valid,
    output swrm_pkg::swrm_ctrl_t             s1_ctrl,
    output logic signed [SAMPLE_BITS-1:0]    taps [WINDOW_MAX]
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (CNT_W > swrm_pkg::LEN_W) ? CNT_W : swrm_pkg::LEN_W;

    logic [swrm_pkg::LEN_W-1:0]    len_reg;
    logic [CNT_W-1:0]              fill_count_reg;
    logic [CNT_W-1:0]              fill_count_next;
    logic                          s1_valid_reg;
    swrm_pkg::swrm_ctrl_t          s1_ctrl_reg;
    swrm_pkg::swrm_ctrl_t          s1_ctrl_next;
    logic signed [SAMPLE_BITS-1:0] win_reg [WINDOW_MAX];
    logic [CMP_W-1:0]              len_ext;
    logic [CMP_W-1:0]              eff_len;
    logic                          accept;

    assign in_ready = !s1_valid_reg || s2_en;
    assign accept   = in_valid && in_ready;
    assign s1_valid = s1_valid_reg;
    assign s1_ctrl  = s1_ctrl_reg;

    // Zero length acts as one, anything above the store depth as the depth
    always_comb
    begin
        len_ext = CMP_W'(len_reg);
        if (len_reg == '0)
        begin
            eff_len = CMP_W'(1);
        end
        else if (len_ext > CMP_W'(WINDOW_MAX))
        begin
            eff_len = CMP_W'(WINDOW_MAX);
        end
        else
        begin
            eff_len = len_ext;
        end
    end

    always_comb
    begin
        if (first)
        begin
            fill_count_next = CNT_W'(1);
        end
        else if (fill_count_reg == CNT_W'(WINDOW_MAX))
        begin
            fill_count_next = fill_count_reg;
        end
        else
        begin
            fill_count_next = fill_count_reg + CNT_W'(1);
        end
        s1_ctrl_next.full  = (CMP_W'(fill_count_next) >= eff_len);
        s1_ctrl_next.first = first;
        s1_ctrl_next.last  = last;
    end

    // Entries beyond the window length mirror the newest sample: neutral for min/max
    always_comb
    begin
        for (int k = 0; k < WINDOW_MAX; k++)
        begin
            if (CMP_W'(k) < eff_len)
            begin
                taps[k] = win_reg[k];
            end
            else
            begin
                taps[k] = win_reg[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= swrm_pkg::LEN_RESET;
            fill_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                fill_count_reg <= fill_count_next;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg <= s1_ctrl_next;
            win_reg[0]  <= sample;
            for (int k = 1; k < WINDOW_MAX; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    a_first_restarts_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && first) |=> (fill_count_reg == CNT_W'(1)))
        else $error("fill count not restarted by first request");

    a_fill_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(WINDOW_MAX))
        else $error("fill count beyond window depth");

endmodule

FILE: rtl/core/swrm_minmax_tree.sv
// Comparator tree giving the minimum and maximum of the masked window taps.
// Purely combinational; depends on nothing.
module swrm_minmax_tree #(
    parameter int N = 16,
    parameter int W = 16
) (
    input  logic signed [W-1:0] taps [N],
    output logic signed [W-1:0] lo,
    output logic signed [W-1:0] hi
);

    localparam int PAD   = 1 << $clog2(N);
    localparam int NODES = 2 * PAD - 1;

    // Heap layout: node n has children 2n+1 and 2n+2, leaves from PAD-1
    logic signed [W-1:0] lo_node [NODES];
    logic signed [W-1:0] hi_node [NODES];

    always_comb
    begin
        for (int i = 0; i < PAD; i++)
        begin
            if (i < N)
            begin
                lo_node[PAD-1+i] = taps[i];
                hi_node[PAD-1+i] = taps[i];
            end
            else
            begin
                lo_node[PAD-1+i] = taps[0];
                hi_node[PAD-1+i] = taps[0];
            end
        end
        for (int n = PAD - 2; n >= 0; n--)
        begin
            lo_node[n] = (lo_node[2*n+2] < lo_node[2*n+1]) ? lo_node[2*n+2] : lo_node[2*n+1];
            hi_node[n] = (hi_node[2*n+2] > hi_node[2*n+1]) ? hi_node[2*n+2] : hi_node[2*n+1];
        end
    end

    assign lo = lo_node[0];
    assign hi = hi_node[0];

endmodule

FILE: rtl/core/swrm_result.sv
// Min/max register (stage 2), range and best-range tracking, output register.
// Depends on swrm_pkg.
module swrm_result #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s1_valid,
    input  swrm_pkg::swrm_ctrl_t          s1_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] tree_lo,
    input  logic signed [SAMPLE_BITS-1:0] tree_hi,
    output logic                          s2_en,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          window_full,
    output logic signed [SAMPLE_BITS-1:0] window_min,
    output logic signed [SAMPLE_BITS-1:0] window_max,
    output logic [SAMPLE_BITS-1:0]        window_range,
    output logic [SAMPLE_BITS-1:0]        best_range,
    output logic                          too_short
);

    logic                          s2_valid_reg;
    swrm_pkg::swrm_ctrl_t          s2_ctrl_reg;
    logic signed [SAMPLE_BITS-1:0] s2_lo_reg;
    logic signed [SAMPLE_BITS-1:0] s2_hi_reg;
    logic [SAMPLE_BITS-1:0]        best_reg;
    logic [SAMPLE_BITS-1:0]        best_next;
    logic [SAMPLE_BITS-1:0]        best_base;
    logic [SAMPLE_BITS-1:0]        rng;
    logic                          out_valid_reg;
    logic                          full_reg;
    logic signed [SAMPLE_BITS-1:0] min_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic [SAMPLE_BITS-1:0]        range_reg;
    logic [SAMPLE_BITS-1:0]        best_out_reg;
    logic                          short_reg;
    logic                          o_en;

    assign o_en  = !out_valid_reg || out_ready;
    assign s2_en = !s2_valid_reg || o_en;

    // Range wraps to the sample width; best restarts with a new sequence
    always_comb
    begin
        rng       = SAMPLE_BITS'(s2_hi_reg - s2_lo_reg);
        best_base = s2_ctrl_reg.first ? '0 : best_reg;
        if (s2_ctrl_reg.full && (rng > best_base))
        begin
            best_next = rng;
        end
        else
        begin
            best_next = best_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            best_reg      <= '0;
        end
        else
        begin
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid;
            end
            if (o_en)
            begin
                out_valid_reg <= s2_valid_reg;
                if (s2_valid_reg)
                begin
                    best_reg <= best_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            s2_ctrl_reg <= s1_ctrl;
            s2_lo_reg   <= tree_lo;
            s2_hi_reg   <= tree_hi;
        end
        if (o_en)
        begin
            full_reg     <= s2_ctrl_reg.full;
            min_reg      <= s2_ctrl_reg.full ? s2_lo_reg : '0;
            max_reg      <= s2_ctrl_reg.full ? s2_hi_reg : '0;
            range_reg    <= s2_ctrl_reg.full ? rng : '0;
            best_out_reg <= best_next;
            short_reg    <= s2_ctrl_reg.last && !s2_ctrl_reg.full;
        end
    end

    assign out_valid    = out_valid_reg;
    assign window_full  = full_reg;
    assign window_min   = min_reg;
    assign window_max   = max_reg;
    assign window_range = range_reg;
    assign best_range   = best_out_reg;
    assign too_short    = short_reg;

    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (o_en && s2_valid_reg && !s2_ctrl_reg.first) |=> (best_reg >= $past(best_reg)))
        else $error("best range fell within a sequence");

    a_range_within_best: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && full_reg) |-> (range_reg <= best_out_reg))
        else $error("window range above reported best");

endmodule

FILE: test/tb.sv
// Testbench for sliding_window_range_max: random and directed sample sequences.
// Keeps its own window model and checks every result in order.
// Depends on swrm_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb;

    localparam int WINDOW_MAX    = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int BLOCK_LATENCY = 2;
    localparam int LONG_HOLD     = 120;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          first;
        logic                          last;
    } window_req_t;

    typedef struct {
        logic                   window_full;
        logic [SAMPLE_BITS-1:0] window_min;
        logic [SAMPLE_BITS-1:0] window_max;
        logic [SAMPLE_BITS-1:0] window_range;
        logic [SAMPLE_BITS-1:0] best_range;
        logic                   too_short;
    } range_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [swrm_pkg::LEN_W-1:0]    cfg_wr_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample = '0;
    logic                          first = 1'b0;
    logic                          last = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          window_full;
    logic signed [SAMPLE_BITS-1:0] window_min;
    logic signed [SAMPLE_BITS-1:0] window_max;
    logic [SAMPLE_BITS-1:0]        window_range;
    logic [SAMPLE_BITS-1:0]        best_range;
    logic                          too_short;

    // model state
    logic signed [SAMPLE_BITS-1:0] hist[WINDOW_MAX];
    int                            fill_cnt = 0;
    logic [SAMPLE_BITS-1:0]        best_seen = '0;
    logic [swrm_pkg::LEN_W-1:0]    len_cfg = swrm_pkg::LEN_RESET;

    window_req_t   pending_q[$];
    range_result_t range_q[$];
    int            error_count = 0;

    // sender and receiver pacing
    int            burst_left = 0;
    int            gap_left = 0;
    window_req_t   next_req;
    logic          hold_armed = 1'b0;
    logic          hold_done = 1'b0;
    int            hold_left = 0;
    int            rx_cycle = 0;
    int            rx_mode = 0;
    logic [31:0]   rx_pattern = '1;

    sliding_window_range_max #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .first        (first),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .window_full  (window_full),
        .window_min   (window_min),
        .window_max   (window_max),
        .window_range (window_range),
        .best_range   (best_range),
        .too_short    (too_short)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int active_len();
        if (len_cfg == 0)
            return 1;
        if (len_cfg > WINDOW_MAX)
            return WINDOW_MAX;
        return len_cfg;
    endfunction

    task automatic track_window(input logic signed [SAMPLE_BITS-1:0] s, input logic f,
                                input logic l);
        range_result_t r;
        int            len;
        int            lo;
        int            hi;
        len = active_len();
        if (f)
        begin
            fill_cnt  = 0;
            best_seen = '0;
        end
        for (int k = WINDOW_MAX - 1; k > 0; k--)
            hist[k] = hist[k-1];
        hist[0] = s;
        if (fill_cnt < WINDOW_MAX)
            fill_cnt++;
        r = '{default: '0};
        if (fill_cnt >= len)
        begin
            lo = hist[0];
            hi = hist[0];
            for (int k = 1; k < len; k++)
            begin
                if (hist[k] < lo)
                    lo = hist[k];
                if (hist[k] > hi)
                    hi = hist[k];
            end
            r.window_full  = 1'b1;
            r.window_min   = SAMPLE_BITS'(lo);
            r.window_max   = SAMPLE_BITS'(hi);
            r.window_range = SAMPLE_BITS'(hi - lo);
            if (r.window_range > best_seen)
                best_seen = r.window_range;
        end
        r.best_range = best_seen;
        r.too_short  = l && !r.window_full;
        range_q.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [SAMPLE_BITS-1:0] exp_v,
                               input logic [SAMPLE_BITS-1:0] act_v);
        if (act_v !== exp_v)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // driver: bursts of requests with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample   <= '0;
            first    <= 1'b0;
            last     <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                track_window(sample, first, last);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || pending_q.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    next_req = pending_q.pop_front();
                    sample   <= next_req.sample;
                    first    <= next_req.first;
                    last     <= next_req.last;
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // receiver: random stall modes and patterns, plus one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle % 64 == 0)
            begin
                rx_mode    = $urandom_range(0, 2);
                rx_pattern = $urandom;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (rx_mode == 0)
                out_ready <= 1'b1;
            else if (rx_mode == 1)
                out_ready <= ($urandom_range(0, 3) != 0);
            else
                out_ready <= rx_pattern[rx_cycle % 32];
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (range_q.size() == 0)
            begin
                error_count++;
                $display("%0t: result with no request outstanding", $time);
            end
            else
            begin
                check_field("window_full", range_q[0].window_full, window_full);
                check_field("window_min", range_q[0].window_min, window_min);
                check_field("window_max", range_q[0].window_max, window_max);
                check_field("window_range", range_q[0].window_range, window_range);
                check_field("best_range", range_q[0].best_range, best_range);
                check_field("too_short", range_q[0].too_short, too_short);
                void'(range_q.pop_front());
            end
        end
    end

    task automatic push_req(input logic signed [SAMPLE_BITS-1:0] s, input logic f,
                            input logic l);
        window_req_t r;
        r.sample = s;
        r.first  = f;
        r.last   = l;
        pending_q.push_back(r);
    endtask

    // hold the sender until the block has drained; checked mid-cycle, clear of the edge
    task automatic wait_drained();
        while (pending_q.size() != 0 || in_valid || range_q.size() != 0)
            @(negedge clk);
        repeat (BLOCK_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_window_len(input logic [swrm_pkg::LEN_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        len_cfg = v;
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int style,
                                                                   input int base);
        case (style)
            0: return SAMPLE_BITS'($urandom);
            1: return SAMPLE_BITS'(base + $signed($urandom_range(0, 64)) - 32);
            2: return ($urandom_range(0, 1) == 0) ? 16'sh8000 : 16'sh7fff;
            default: return SAMPLE_BITS'(base);
        endcase
    endfunction

    task automatic add_random_phase(input int n_req);
        int count;
        int kind;
        int seq_len;
        int style;
        int base;
        int len;
        logic f;
        logic l;
        count = 0;
        len = active_len();
        while (count < n_req)
        begin
            kind  = $urandom_range(0, 9);
            style = $urandom_range(0, 3);
            base  = $signed(SAMPLE_BITS'($urandom));
            if (kind == 8)
            begin
                // loose requests with random flags
                seq_len = $urandom_range(1, 5);
                for (int i = 0; i < seq_len; i++)
                    push_req(pick_sample(style, base), $urandom_range(0, 3) == 0,
                             $urandom_range(0, 3) == 0);
            end
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    seq_len = $urandom_range(1, len);
                else
                    seq_len = $urandom_range(len, 3 * len + 4);
                for (int i = 0; i < seq_len; i++)
                begin
                    f = (i == 0);
                    l = (i == seq_len - 1);
                    // broken sequence: drop either the first or the last flag
                    if (kind == 9)
                    begin
                        if (style[0])
                            f = 1'b0;
                        else
                            l = 1'b0;
                    end
                    push_req(pick_sample(style, base), f, l);
                end
            end
            count += seq_len;
        end
    endtask

    initial
    begin
        logic [swrm_pkg::LEN_W-1:0] len_plan[10];
        len_plan = '{5'd16, 5'd0, 5'd31, 5'd17, 5'd2, 5'd1, 5'd5, 5'd0, 5'd0, 5'd0};
        for (int i = 7; i < 10; i++)
            len_plan[i] = $urandom_range(0, 31);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // window length 1 from reset; no first flag on the opening request
        push_req(16'sh7fff, 1'b0, 1'b0);
        push_req(16'sh8000, 1'b0, 1'b0);
        push_req(16'sh0000, 1'b0, 1'b1);
        wait_drained();

        write_window_len(5'd3);
        push_req(16'sd5, 1'b1, 1'b1);
        push_req(16'sh7fff, 1'b1, 1'b0);
        push_req(16'sh8000, 1'b0, 1'b1);
        push_req(16'sh8000, 1'b1, 1'b0);
        push_req(16'sh7fff, 1'b0, 1'b0);
        push_req(16'sh8000, 1'b0, 1'b0);
        push_req(16'sh7fff, 1'b0, 1'b0);
        push_req(-16'sd1, 1'b0, 1'b1);
        push_req(16'sd7, 1'b1, 1'b0);
        push_req(16'sd7, 1'b0, 1'b0);
        push_req(16'sd7, 1'b0, 1'b0);
        push_req(-16'sd7, 1'b0, 1'b1);
        // carries on past last without a new first
        push_req(16'sd100, 1'b0, 1'b0);
        push_req(-16'sd100, 1'b0, 1'b0);
        wait_drained();

        // longer window mid-sequence: history kept, window not yet full
        write_window_len(5'd16);
        push_req(16'sh5555, 1'b0, 1'b0);
        push_req(16'shaaaa, 1'b0, 1'b1);
        wait_drained();

        for (int p = 0; p < 10; p++)
        begin
            write_window_len(len_plan[p]);
            add_random_phase(115);
            if (p == 3)
                hold_armed <= 1'b1;
            wait_drained();
        end

        repeat (BLOCK_LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
